// File: rtl/core/sha256_pkg.sv
// ----------------------------------------------------------------------------
// SHA-256 package
// Round constants, initial hash values, state encoding and round helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package sha256_pkg;

    localparam int unsigned WORD_W   = 32;
    localparam int unsigned ROUNDS   = 64;
    localparam logic [7:0]  PAD_BYTE = 8'h80;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_ROUND,
        ST_FOLD,
        ST_EMIT
    } state_t;

    typedef enum logic {
        KIND_DATA   = 1'b0,
        KIND_FINISH = 1'b1
    } kind_t;

    function automatic logic [31:0] round_k(input logic [5:0] idx);
        logic [31:0] k;
        case (idx)
            6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7;  default: k = 32'hc67178f2;
        endcase
        return k;
    endfunction

    function automatic logic [31:0] init_hash(input logic [2:0] idx);
        logic [31:0] h;
        case (idx)
            3'd0: h = 32'h6a09e667;
            3'd1: h = 32'hbb67ae85;
            3'd2: h = 32'h3c6ef372;
            3'd3: h = 32'ha54ff53a;
            3'd4: h = 32'h510e527f;
            3'd5: h = 32'h9b05688c;
            3'd6: h = 32'h1f83d9ab;
            default: h = 32'h5be0cd19;
        endcase
        return h;
    endfunction

    function automatic logic [31:0] rotr(input logic [31:0] v, input int unsigned n);
        return (v >> n) | (v << (WORD_W - n));
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/sha256_stream_hasher_unit.sv
// ----------------------------------------------------------------------------
// SHA-256 stream hasher
// Byte-serial SHA-256 with one shared round unit and a 16-word schedule window.
// ----------------------------------------------------------------------------
// Input channel (valid/ready): kind, data_byte. A data byte transfer is taken
// while the block is filling. The 64th byte of a block starts a compression:
// the rounds, then a fold, with ready low meanwhile.
// A finish transfer pads the block one padding byte at a time (up to 64 per
// block), then one compression, or two when 56 or more bytes were held.
// The digest then leaves on the output channel (valid/ready) as eight word
// transfers, index 0 first, last_word on the eighth; one word per cycle
// when the receiver is ready, held while it stalls. Input ready stays low
// until the last word is taken; chaining state then returns to the initial
// hash values.
// Throughput is one byte per cycle between compressions, set by the
// single round unit.
// Reset (rst_n, asynchronous) loads the initial hash values, clears the fill
// and bit counters and returns to idle with no output pending.
// ----------------------------------------------------------------------------
`default_nettype none

module sha256_stream_hasher_unit
    import sha256_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        kind,
    input  wire logic [7:0]  data_byte,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [31:0]      digest_word,
    output logic [2:0]       word_index,
    output logic             last_word
);

    state_t      state_reg, state_next;
    logic [31:0] chain_reg [8];
    logic [31:0] va_reg [8];
    logic [31:0] w_reg [16];
    logic [6:0]  fill_reg, fill_next;
    logic [63:0] bits_reg;
    logic [5:0]  round_reg;
    logic [2:0]  widx_reg;
    logic        final_reg;
    logic        second_reg;

    logic        in_xfer, out_xfer;
    logic        shift_in;
    logic [7:0]  shift_byte;
    logic [31:0] w_cur, w_new, s0, s1, t1, t2, sum1, sum0, ch, maj;
    logic [63:0] len_bits;

    assign in_xfer = in_valid && in_ready;
    assign out_xfer = out_valid && out_ready;
    assign in_ready = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_EMIT);
    assign digest_word = chain_reg[widx_reg];
    assign word_index = widx_reg;
    assign last_word = (widx_reg == 3'd7);

    assign len_bits = bits_reg + {55'd0, fill_reg[5:0], 3'd0};

    // Byte to shift in: the data byte while filling, else the padding byte for the current fill position
    always_comb
    begin
        shift_in = 1'b0;
        shift_byte = data_byte;
        if (state_reg == ST_IDLE && in_xfer && kind == KIND_DATA) begin
            shift_in = 1'b1;
        end else if (state_reg == ST_PAD) begin
            shift_in = 1'b1;
            if (!second_reg && fill_reg == {1'b0, fill_reg[5:0]} && !final_reg)
                shift_byte = PAD_BYTE;
            else if (fill_reg[5:3] == 3'd7 && !second_reg)
                shift_byte = bits_reg[6'd63 - {fill_reg[2:0], 3'd0} -: 8];
            else
                shift_byte = 8'h00;
        end
    end

    assign w_cur = w_reg[0];
    assign s0 = rotr(w_reg[1], 7) ^ rotr(w_reg[1], 18) ^ (w_reg[1] >> 3);
    assign s1 = rotr(w_reg[14], 17) ^ rotr(w_reg[14], 19) ^ (w_reg[14] >> 10);
    assign w_new = s1 + w_reg[9] + s0 + w_reg[0];
    assign sum1 = rotr(va_reg[4], 6) ^ rotr(va_reg[4], 11) ^ rotr(va_reg[4], 25);
    assign ch = (va_reg[4] & va_reg[5]) ^ (~va_reg[4] & va_reg[6]);
    assign t1 = va_reg[7] + sum1 + ch + round_k(round_reg) + w_cur;
    assign sum0 = rotr(va_reg[0], 2) ^ rotr(va_reg[0], 13) ^ rotr(va_reg[0], 22);
    assign maj = (va_reg[0] & va_reg[1]) ^ (va_reg[0] & va_reg[2])
               ^ (va_reg[1] & va_reg[2]);
    assign t2 = sum0 + maj;

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        fill_next = fill_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer) begin
                    if (kind == KIND_DATA) begin
                        fill_next = fill_reg + 7'd1;
                        if (fill_reg == 7'd63)
                            state_next = ST_ROUND;
                    end else begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_PAD:
            begin
                fill_next = fill_reg + 7'd1;
                if (fill_reg[5:0] == 6'd63)
                    state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                if (round_reg == 6'(ROUNDS - 1))
                    state_next = ST_FOLD;
            end
            ST_FOLD:
            begin
                fill_next = 7'd0;
                if (!final_reg)
                    state_next = ST_IDLE;
                else if (second_reg)
                    state_next = ST_PAD;
                else
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_xfer && widx_reg == 3'd7)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= ST_IDLE;
            fill_reg <= 7'd0;
            bits_reg <= 64'd0;
            round_reg <= 6'd0;
            widx_reg <= 3'd0;
            final_reg <= 1'b0;
            second_reg <= 1'b0;
            for (int i = 0; i < 8; i++)
                chain_reg[i] <= init_hash(3'(i));
        end else begin
            state_reg <= state_next;
            fill_reg <= fill_next;
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_xfer && kind == KIND_FINISH) begin
                        // final_reg low here marks the 0x80 slot on the first pad cycle
                        final_reg <= 1'b0;
                        second_reg <= 1'b0;
                    end
                    round_reg <= 6'd0;
                end
                ST_PAD:
                begin
                    if (!final_reg && !second_reg) begin
                        bits_reg <= len_bits;
                        second_reg <= (fill_reg[5:0] >= 6'd56);
                        final_reg <= 1'b1;
                    end
                    round_reg <= 6'd0;
                end
                ST_ROUND:
                begin
                    round_reg <= round_reg + 6'd1;
                end
                ST_FOLD:
                begin
                    for (int i = 0; i < 8; i++)
                        chain_reg[i] <= chain_reg[i] + va_reg[i];
                    if (!final_reg)
                        bits_reg <= bits_reg + 64'd512;
                    if (final_reg && second_reg) begin
                        second_reg <= 1'b0;
                        final_reg <= 1'b1;
                    end
                    widx_reg <= 3'd0;
                end
                ST_EMIT:
                begin
                    if (out_xfer) begin
                        widx_reg <= widx_reg + 3'd1;
                        if (widx_reg == 3'd7) begin
                            for (int i = 0; i < 8; i++)
                                chain_reg[i] <= init_hash(3'(i));
                            bits_reg <= 64'd0;
                            final_reg <= 1'b0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // Pad path detail: in ST_PAD the first cycle writes 0x80 and sets final_reg;
    // later cycles write zero, or length bytes in slots 56..63 of the last block.
    // For the overflow block second_reg is high, so the length slots stay zero.

    // Schedule window and working variables (payload, no reset)
    always_ff @(posedge clk)
    begin
        if (shift_in) begin
            if (state_reg == ST_PAD && final_reg && second_reg)
                w_reg[15] <= {w_reg[15][23:0], 8'h00};
            else
                w_reg[15] <= {w_reg[15][23:0], shift_byte};
            if (fill_reg[1:0] == 2'd0) begin
                for (int i = 0; i < 15; i++)
                    w_reg[i] <= w_reg[i + 1];
            end
            for (int i = 0; i < 8; i++)
                va_reg[i] <= chain_reg[i];
        end else if (state_reg == ST_ROUND) begin
            for (int i = 0; i < 15; i++)
                w_reg[i] <= w_reg[i + 1];
            w_reg[15] <= w_new;
            va_reg[7] <= va_reg[6];
            va_reg[6] <= va_reg[5];
            va_reg[5] <= va_reg[4];
            va_reg[4] <= va_reg[3] + t1;
            va_reg[3] <= va_reg[2];
            va_reg[2] <= va_reg[1];
            va_reg[1] <= va_reg[0];
            va_reg[0] <= t1 + t2;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("input taken during digest output");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROUND && round_reg == 6'd63) |=> state_reg == ST_FOLD)
        else $error("round count did not end in fold");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(widx_reg)))
        else $error("digest word moved under stall");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> fill_reg < 7'd64)
        else $error("fill count overflow while idle");

endmodule

`default_nettype wire

// File: tb/sv/tb_sha256_stream_hasher_unit.sv
// ----------------------------------------------------------------------------
// SHA-256 stream hasher testbench
// Feeds byte-serial messages and finish transfers, predicts each digest with
// a local SHA-256 model and checks every digest word transfer in order.
// ----------------------------------------------------------------------------
module tb_sha256_stream_hasher_unit;
    import sha256_pkg::*;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] data_byte;
    } msg_item_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } digest_item_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic        kind;
    logic [7:0]  data_byte;
    logic        out_valid;
    logic        out_ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    sha256_stream_hasher_unit dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .kind(kind), .data_byte(data_byte),
        .out_valid(out_valid), .out_ready(out_ready),
        .digest_word(digest_word), .word_index(word_index), .last_word(last_word)
    );

    localparam logic [31:0] K_TAB [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };
    localparam logic [31:0] IV_TAB [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    logic [31:0] hash_state [8];
    logic [7:0]  blk_buf [64];
    int unsigned blk_fill;
    logic [63:0] msg_bits;

    msg_item_t    pending_q [$];
    digest_item_t digest_q [$];
    int unsigned  n_mismatch;
    int unsigned  cycle_cnt;
    int unsigned  tx_idle_pct;
    int unsigned  rx_idle_pct;
    int unsigned  rx_hold;

    function automatic logic [31:0] ror(logic [31:0] v, int unsigned n);
        return (v >> n) | (v << (32 - n));
    endfunction

    function automatic void hash_block();
        logic [31:0] w [64];
        logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
        for (int i = 0; i < 16; i++)
            w[i] = {blk_buf[4*i], blk_buf[4*i+1], blk_buf[4*i+2], blk_buf[4*i+3]};
        for (int i = 16; i < 64; i++)
            w[i] = (ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10)) + w[i-7]
                 + (ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-16];
        a = hash_state[0]; b = hash_state[1]; c = hash_state[2]; d = hash_state[3];
        e = hash_state[4]; f = hash_state[5]; g = hash_state[6]; h = hash_state[7];
        for (int i = 0; i < 64; i++)
        begin
            t1 = h + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & f) ^ (~e & g))
               + K_TAB[i] + w[i];
            t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1;
            d = c; c = b; b = a; a = t1 + t2;
        end
        hash_state[0] += a; hash_state[1] += b; hash_state[2] += c; hash_state[3] += d;
        hash_state[4] += e; hash_state[5] += f; hash_state[6] += g; hash_state[7] += h;
    endfunction

    function automatic void restart_msg();
        for (int i = 0; i < 8; i++)
            hash_state[i] = IV_TAB[i];
        blk_fill = 0;
        msg_bits = '0;
    endfunction

    function automatic void absorb_item(msg_item_t it);
        int unsigned p;
        digest_item_t r;
        if (it.kind == KIND_DATA)
        begin
            blk_buf[blk_fill] = it.data_byte;
            blk_fill++;
            if (blk_fill == 64)
            begin
                hash_block();
                msg_bits += 64'd512;
                blk_fill = 0;
            end
            return;
        end
        p = blk_fill;
        msg_bits += 64'(p) * 8;
        blk_buf[p] = PAD_BYTE;
        p++;
        if (p > 56)
        begin
            while (p < 64) begin blk_buf[p] = 8'h00; p++; end
            hash_block();
            p = 0;
        end
        while (p < 56) begin blk_buf[p] = 8'h00; p++; end
        for (int i = 0; i < 8; i++)
            blk_buf[56+i] = msg_bits[63-8*i -: 8];
        hash_block();
        for (int i = 0; i < 8; i++)
        begin
            r.digest_word = hash_state[i];
            r.word_index  = 3'(i);
            r.last_word   = (i == 7);
            digest_q.push_back(r);
        end
        restart_msg();
    endfunction

    function automatic void queue_msg(int unsigned len);
        msg_item_t it;
        for (int i = 0; i < len; i++)
        begin
            it.kind = KIND_DATA;
            it.data_byte = 8'($urandom_range(0, 255));
            pending_q.push_back(it);
        end
        it.kind = KIND_FINISH;
        it.data_byte = 8'($urandom_range(0, 255));
        pending_q.push_back(it);
    endfunction

    initial clk = 1'b0;
    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > 400000)
        begin
            $display("sha256_stream_hasher_unit: mismatch");
            $finish;
        end
    end

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            kind      <= 1'b0;
            data_byte <= 8'h00;
        end
        else
        begin
            if (in_valid && in_ready)
                absorb_item(msg_item_t'{kind_t'(kind), data_byte});
            if ((!in_valid || in_ready) && pending_q.size() > 0
                && $urandom_range(1, 100) > tx_idle_pct)
            begin
                msg_item_t it;
                it = pending_q.pop_front();
                in_valid  <= 1'b1;
                kind      <= it.kind;
                data_byte <= it.data_byte;
            end
            else if (in_valid && in_ready)
                in_valid <= 1'b0;
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (digest_q.size() == 0)
                begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("unexpected transfer: word %h idx %0d", digest_word,
                                 word_index);
                end
                else
                begin
                    digest_item_t x;
                    x = digest_q.pop_front();
                    if (x != digest_item_t'{digest_word, word_index, last_word})
                    begin
                        n_mismatch++;
                        if (n_mismatch <= 10)
                            $display("exp %h/%0d/%0d got %h/%0d/%0d", x.digest_word,
                                     x.word_index, x.last_word, digest_word,
                                     word_index, last_word);
                    end
                end
            end
            if (rx_hold > 0)
            begin
                rx_hold   <= rx_hold - 1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(1, 100) > rx_idle_pct);
        end
    end

    initial
    begin
        msg_item_t it;
        rst_n = 1'b0;
        n_mismatch = 0;
        cycle_cnt = 0;
        tx_idle_pct = 28;
        rx_idle_pct = 81;
        rx_hold = 0;
        restart_msg();
        for (int i = 0; i < 64; i++)
            blk_buf[i] = 8'h00;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty message, finish with byte ignored, extreme bytes
        it = msg_item_t'{KIND_FINISH, 8'h00}; pending_q.push_back(it);
        it = msg_item_t'{KIND_FINISH, 8'hff}; pending_q.push_back(it);
        it = msg_item_t'{KIND_DATA, 8'h00};   pending_q.push_back(it);
        it = msg_item_t'{KIND_DATA, 8'hff};   pending_q.push_back(it);
        it = msg_item_t'{KIND_FINISH, 8'h55}; pending_q.push_back(it);
        it = msg_item_t'{KIND_DATA, 8'haa};   pending_q.push_back(it);
        it = msg_item_t'{KIND_FINISH, 8'haa}; pending_q.push_back(it);
        // padding overflow and full-block boundaries
        queue_msg(55);
        queue_msg(56);
        queue_msg(64);

        // long receiver hold-off while the sender keeps offering
        rx_hold = 600;
        for (int ph = 0; ph < 3; ph++)
        begin
            if (ph == 1) begin tx_idle_pct = 81; rx_idle_pct = 28; end
            if (ph == 2) begin tx_idle_pct = 0;  rx_idle_pct = 0;  end
            for (int m = 0; m < 4; m++)
                queue_msg($urandom_range(0, 14));
            while (pending_q.size() > 0 || digest_q.size() > 0 || in_valid)
                @(posedge clk);
        end

        repeat (300) @(posedge clk);
        if (n_mismatch == 0 && digest_q.size() == 0)
            $display("sha256_stream_hasher_unit: match");
        else
            $display("sha256_stream_hasher_unit: mismatch");
        $finish;
    end
endmodule
